// File: hw/rtl/tzpc_pkg.sv
// ============================================================================
// tzpc_pkg
// Shared types and constants for the two-zone people counter.
// ============================================================================
package tzpc_pkg;

    localparam int unsigned DIST_W  = 15;
    localparam int unsigned COUNT_W = 8;

    // Threshold value after reset, in sensor units
    localparam logic [DIST_W-1:0] THRESHOLD_RESET = 15'd1000;

    // Region under the sensor
    typedef enum logic [1:0] {
        RG_OUT   = 2'd0,
        RG_FRONT = 2'd1,
        RG_DOOR  = 2'd2,
        RG_BACK  = 2'd3
    } region_t;

    // Crossing event reported with each word
    typedef enum logic [1:0] {
        CROSS_NONE  = 2'd0,
        CROSS_ENTRY = 2'd1,
        CROSS_EXIT  = 2'd2
    } crossing_t;

    // Result of one path update, carried from tracker to output register
    typedef struct packed {
        region_t              region;
        logic [COUNT_W-1:0]   count;
        crossing_t            crossing;
        logic [1:0]           step;
    } path_result_t;

endpackage

// File: hw/rtl/two_zone_people_counter_core.sv
// ============================================================================
// two_zone_people_counter_core
// Two-zone people counter: classifies each distance pair and counts
// complete crossings in a signed 8-bit occupancy count.
//
//   channel | ports                                          | handshake
//   --------+------------------------------------------------+--------------
//   in      | front_distance, back_distance                  | in_valid/in_stall
//   out     | region, occupancy_count, crossing, path_step   | out_valid/out_stall
//   cfg     | threshold_wdata                                | threshold_we
//
// One word per cycle while out_stall is low; each word passes the input register,
// then the result register. Classification and path update sit between them.
// Reset clears the path, the count and the valid flags; threshold resets
// to 1000. out_stall holds the result register and, once the input
// register is also full, raises in_stall in the same cycle.
// ============================================================================
module two_zone_people_counter_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [tzpc_pkg::DIST_W-1:0]   front_distance,
    input  logic [tzpc_pkg::DIST_W-1:0]   back_distance,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    region,
    output logic signed [tzpc_pkg::COUNT_W-1:0] occupancy_count,
    output logic [1:0]                    crossing,
    output logic [1:0]                    path_step,
    input  logic                          threshold_we,
    input  logic [tzpc_pkg::DIST_W-1:0]   threshold_wdata
);

    logic [tzpc_pkg::DIST_W-1:0] threshold_reg;
    logic                        in_valid_reg;
    logic [tzpc_pkg::DIST_W-1:0] front_reg;
    logic [tzpc_pkg::DIST_W-1:0] back_reg;
    logic                        out_valid_reg;
    tzpc_pkg::path_result_t      result_reg;
    tzpc_pkg::path_result_t      result_next;
    tzpc_pkg::region_t           cur_region;
    logic                        advance;
    logic                        in_take;

    // Pipeline control: result register frees up, input register drains
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= tzpc_pkg::THRESHOLD_RESET;
        end
        else if (threshold_we)
        begin
            threshold_reg <= threshold_wdata;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            front_reg <= front_distance;
            back_reg  <= back_distance;
        end
    end

    tzpc_classify u_classify
    (
        .front_dist (front_reg),
        .back_dist  (back_reg),
        .threshold  (threshold_reg),
        .region     (cur_region)
    );

    tzpc_path u_path
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (in_valid_reg && advance),
        .region (cur_region),
        .result (result_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign region          = result_reg.region;
    assign occupancy_count = result_reg.count;
    assign crossing        = result_reg.crossing;
    assign path_step       = result_reg.step;

endmodule

// File: hw/rtl/tzpc_classify.sv
// ============================================================================
// tzpc_classify
// Region classifier: compares both zone distances against the threshold.
// ============================================================================
module tzpc_classify
(
    input  logic [tzpc_pkg::DIST_W-1:0] front_dist,
    input  logic [tzpc_pkg::DIST_W-1:0] back_dist,
    input  logic [tzpc_pkg::DIST_W-1:0] threshold,
    output tzpc_pkg::region_t           region
);

    logic front_lt;
    logic back_lt;
    logic front_le;
    logic back_le;

    assign front_lt = (front_dist < threshold);
    assign back_lt  = (back_dist  < threshold);
    assign front_le = (front_dist <= threshold);
    assign back_le  = (back_dist  <= threshold);

    // Tests in priority order: front, door, back, else out
    always_comb
    begin
        if (!back_lt && front_lt)
        begin
            region = tzpc_pkg::RG_FRONT;
        end
        else if (front_le && back_le)
        begin
            region = tzpc_pkg::RG_DOOR;
        end
        else if (!front_lt && back_lt)
        begin
            region = tzpc_pkg::RG_BACK;
        end
        else
        begin
            region = tzpc_pkg::RG_OUT;
        end
    end

endmodule

// File: hw/rtl/tzpc_path.sv
// ============================================================================
// tzpc_path
// Path tracker: records the out/side/door/side sequence and keeps the
// signed occupancy count.
// ============================================================================
module tzpc_path
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   update,
    input  tzpc_pkg::region_t      region,
    output tzpc_pkg::path_result_t result
);

    logic [1:0]                   pos_reg;
    logic [1:0]                   pos_next;
    tzpc_pkg::region_t            entry_reg  [3];
    tzpc_pkg::region_t            entry_next [3];
    logic [tzpc_pkg::COUNT_W-1:0] count_reg;
    logic [tzpc_pkg::COUNT_W-1:0] count_next;
    tzpc_pkg::crossing_t          crossing;
    logic                         side;

    assign side = (region == tzpc_pkg::RG_FRONT) || (region == tzpc_pkg::RG_BACK);

    // Next path state and count
    always_comb
    begin
        pos_next      = pos_reg;
        entry_next[0] = entry_reg[0];
        entry_next[1] = entry_reg[1];
        entry_next[2] = entry_reg[2];
        count_next    = count_reg;
        crossing      = tzpc_pkg::CROSS_NONE;

        if (region == tzpc_pkg::RG_OUT)
        begin
            // complete path: count only front-door-back or back-door-front
            if (pos_reg == 2'd3)
            begin
                if (entry_reg[0] == tzpc_pkg::RG_FRONT &&
                    entry_reg[1] == tzpc_pkg::RG_DOOR &&
                    entry_reg[2] == tzpc_pkg::RG_BACK)
                begin
                    count_next = count_reg + 8'd1;
                    crossing   = tzpc_pkg::CROSS_ENTRY;
                end
                else if (entry_reg[0] == tzpc_pkg::RG_BACK &&
                         entry_reg[1] == tzpc_pkg::RG_DOOR &&
                         entry_reg[2] == tzpc_pkg::RG_FRONT)
                begin
                    count_next = count_reg - 8'd1;
                    crossing   = tzpc_pkg::CROSS_EXIT;
                end
            end
            pos_next      = 2'd0;
            entry_next[0] = tzpc_pkg::RG_OUT;
            entry_next[1] = tzpc_pkg::RG_OUT;
            entry_next[2] = tzpc_pkg::RG_OUT;
        end
        else if (side && pos_reg == 2'd0)
        begin
            entry_next[0] = region;
            pos_next      = 2'd1;
        end
        else if (side && pos_reg == 2'd2)
        begin
            entry_next[2] = region;
            pos_next      = 2'd3;
        end
        else if (region == tzpc_pkg::RG_DOOR && pos_reg == 2'd1)
        begin
            entry_next[1] = region;
            pos_next      = 2'd2;
        end
    end

    // State registers, advanced once per word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= 2'd0;
            entry_reg[0] <= tzpc_pkg::RG_OUT;
            entry_reg[1] <= tzpc_pkg::RG_OUT;
            entry_reg[2] <= tzpc_pkg::RG_OUT;
            count_reg    <= '0;
        end
        else if (update)
        begin
            pos_reg      <= pos_next;
            entry_reg[0] <= entry_next[0];
            entry_reg[1] <= entry_next[1];
            entry_reg[2] <= entry_next[2];
            count_reg    <= count_next;
        end
    end

    assign result.region   = region;
    assign result.count    = count_next;
    assign result.crossing = crossing;
    assign result.step     = pos_next;

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb: two_zone_people_counter_core testbench
// Drives distance words through the counter with random gaps on both sides,
// predicts region, occupancy count, crossing and path step for every
// accepted word, and checks each result word in order against it.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tzpc_pkg::*;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [DIST_W-1:0]          front_distance;
    logic [DIST_W-1:0]          back_distance;
    logic                       out_valid;
    logic                       out_stall;
    logic [1:0]                 region;
    logic signed [COUNT_W-1:0]  occupancy_count;
    logic [1:0]                 crossing;
    logic [1:0]                 path_step;
    logic                       threshold_we;
    logic [DIST_W-1:0]          threshold_wdata;

    // Tracker copy kept by the testbench
    logic [DIST_W-1:0]   trk_threshold = THRESHOLD_RESET;
    logic [1:0]          trk_step      = '0;
    region_t             trk_trail [3] = '{RG_OUT, RG_OUT, RG_OUT};
    logic [COUNT_W-1:0]  trk_count     = '0;

    path_result_t pending_results [$];
    int           error_count = 0;
    int           words_sent  = 0;
    bit           no_idle     = 1'b0;

    two_zone_people_counter_core dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .front_distance  (front_distance),
        .back_distance   (back_distance),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .region          (region),
        .occupancy_count (occupancy_count),
        .crossing        (crossing),
        .path_step       (path_step),
        .threshold_we    (threshold_we),
        .threshold_wdata (threshold_wdata)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard limit on run length
    initial
    begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    // Region classification; order of tests decides the boundaries
    function automatic region_t zone_of(input logic [DIST_W-1:0] f, b, t);
        if (b >= t && f < t)
            return RG_FRONT;
        if (f <= t && b <= t)
            return RG_DOOR;
        if (f >= t && b < t)
            return RG_BACK;
        return RG_OUT;
    endfunction

    // Advance the path tracker by one word and return the expected result
    function automatic path_result_t track_word(input logic [DIST_W-1:0] f, b);
        path_result_t res;
        region_t      z;
        crossing_t    c;
        z = zone_of(f, b, trk_threshold);
        c = CROSS_NONE;
        if (z == RG_OUT)
        begin
            if (trk_step == 2'd3)
            begin
                if (trk_trail[0] == RG_FRONT && trk_trail[1] == RG_DOOR &&
                    trk_trail[2] == RG_BACK)
                begin
                    trk_count = trk_count + 8'd1;
                    c = CROSS_ENTRY;
                end
                else if (trk_trail[0] == RG_BACK && trk_trail[1] == RG_DOOR &&
                         trk_trail[2] == RG_FRONT)
                begin
                    trk_count = trk_count - 8'd1;
                    c = CROSS_EXIT;
                end
            end
            trk_step  = '0;
            trk_trail = '{RG_OUT, RG_OUT, RG_OUT};
        end
        else if ((z == RG_FRONT || z == RG_BACK) && (trk_step == 2'd0 || trk_step == 2'd2))
        begin
            trk_trail[trk_step] = z;
            trk_step = trk_step + 2'd1;
        end
        else if (z == RG_DOOR && trk_step == 2'd1)
        begin
            trk_trail[1] = z;
            trk_step = 2'd2;
        end
        res.region   = z;
        res.count    = trk_count;
        res.crossing = c;
        res.step     = trk_step;
        return res;
    endfunction

    // Idle cycles before the next word; zero is drawn often
    function automatic int idle_cycles();
        if (no_idle || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    // Value in [lo, hi], biased toward the two ends
    function automatic logic [DIST_W-1:0] span(input int unsigned lo, hi);
        case ($urandom_range(0, 7))
            0:       return DIST_W'(lo);
            1:       return DIST_W'(hi);
            default: return DIST_W'($urandom_range(hi, lo));
        endcase
    endfunction

    // Random distance pair that lands in the wanted region
    function automatic void pair_for(input region_t want,
                                     output logic [DIST_W-1:0] f, b);
        int unsigned t;
        t = {17'd0, trk_threshold};
        for (int i = 0; i < 20; i++)
        begin
            case (want)
                RG_FRONT: begin f = span(0, t - 1); b = span(t, DIST_MAX); end
                RG_BACK:  begin f = span(t, DIST_MAX); b = span(0, t - 1); end
                RG_DOOR:  begin f = span(0, t); b = span(0, t); end
                default:  begin f = span(t, DIST_MAX); b = span(t, DIST_MAX); end
            endcase
            if (zone_of(f, b, trk_threshold) == want)
                return;
        end
    endfunction

    // Send one word; the prediction is made when it is accepted
    task automatic send_word(input logic [DIST_W-1:0] f, b);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        front_distance <= f;
        back_distance  <= b;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(track_word(f, b));
        words_sent++;
    endtask

    task automatic send_region(input region_t z);
        logic [DIST_W-1:0] f, b;
        pair_for(z, f, b);
        send_word(f, b);
    endtask

    // One region held for one to three words
    task automatic send_run(input region_t z);
        repeat ($urandom_range(0, 2) == 0 ? $urandom_range(2, 3) : 1)
            send_region(z);
    endtask

    // Full walk: side, door, side, then out
    task automatic send_trail(input region_t first, last);
        send_run(first);
        send_run(RG_DOOR);
        send_run(last);
        send_run(RG_OUT);
    endtask

    // Stop sending and wait until every expected word has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [DIST_W-1:0] value);
        drain();
        threshold_we    <= 1'b1;
        threshold_wdata <= value;
        @(posedge clk);
        threshold_we  <= 1'b0;
        trk_threshold = value;
    endtask

    // Region edges at the reset threshold of 1000
    task automatic test_boundaries();
        send_word(DIST_MAX, DIST_MAX);
        send_word(15'd999, 15'd1000);
        send_word(15'd1000, 15'd1000);
        send_word(15'd1000, 15'd999);
        send_word(15'd0, 15'd0);
        send_word(15'd1001, 15'd1000);
        send_word(15'd999, DIST_MAX);
        send_word(DIST_MAX, 15'd0);
        send_word(15'd1000, 15'd1001);
        drain();
    endtask

    // Counting walks, non-counting walks, aborts and ignored regions
    task automatic test_paths();
        send_trail(RG_FRONT, RG_BACK);
        send_trail(RG_BACK, RG_FRONT);
        send_trail(RG_FRONT, RG_FRONT);
        send_trail(RG_BACK, RG_BACK);
        // aborts at step one and step two
        send_region(RG_FRONT);
        send_region(RG_OUT);
        send_region(RG_BACK);
        send_region(RG_DOOR);
        send_region(RG_OUT);
        // regions that do not fit the current step are ignored
        send_region(RG_DOOR);
        send_region(RG_FRONT);
        send_region(RG_BACK);
        send_region(RG_DOOR);
        send_region(RG_FRONT);
        send_region(RG_BACK);
        send_region(RG_DOOR);
        send_region(RG_OUT);
        drain();
    endtask

    // Threshold at both ends and next to them; path survives the writes
    task automatic test_threshold_extremes();
        write_threshold('0);
        send_word(15'd0, 15'd0);
        send_word(15'd0, 15'd1);
        send_word(15'd1, 15'd0);
        send_word(DIST_MAX, DIST_MAX);
        write_threshold(DIST_MAX);
        send_word(DIST_MAX - 15'd1, DIST_MAX);
        send_word(DIST_MAX, DIST_MAX);
        send_word(DIST_MAX, DIST_MAX - 15'd1);
        send_word(15'd0, 15'd0);
        write_threshold(15'd1);
        send_word(15'd2, 15'd2);
        send_word(15'd1, 15'd0);
        send_word(15'd1, 15'd1);
        send_word(15'd0, 15'd1);
        send_word(DIST_MAX, DIST_MAX);
        write_threshold(DIST_MAX - 15'd1);
        send_word(DIST_MAX, DIST_MAX);
        send_word(DIST_MAX - 15'd2, DIST_MAX - 15'd1);
        send_word(DIST_MAX - 15'd1, DIST_MAX - 15'd1);
        send_word(DIST_MAX - 15'd1, DIST_MAX - 15'd2);
        send_word(DIST_MAX, DIST_MAX);
        drain();
    endtask

    // Count up to 127, wrap to -128, then back down through the wrap
    task automatic test_count_wrap();
        write_threshold(THRESHOLD_RESET);
        no_idle = 1'b1;
        send_region(RG_OUT);
        while (trk_count != 8'd127)
            send_trail(RG_FRONT, RG_BACK);
        no_idle = 1'b0;
        send_trail(RG_FRONT, RG_BACK);
        send_trail(RG_BACK, RG_FRONT);
        send_trail(RG_BACK, RG_FRONT);
        drain();
    endtask

    // Mostly well-formed walks with random content, plus broken walks and noise
    task automatic random_sequence();
        int                kind;
        region_t           side;
        logic [DIST_W-1:0] f, b;
        kind = $urandom_range(0, 99);
        side = ($urandom_range(0, 1) != 0) ? RG_FRONT : RG_BACK;
        if (kind < 35)
            send_trail(RG_FRONT, RG_BACK);
        else if (kind < 70)
            send_trail(RG_BACK, RG_FRONT);
        else if (kind < 80)
            send_trail(side, ($urandom_range(0, 1) != 0) ? RG_FRONT : RG_BACK);
        else if (kind < 90)
        begin
            repeat ($urandom_range(1, 6))
                send_region(region_t'($urandom_range(0, 3)));
        end
        else
        begin
            repeat ($urandom_range(1, 6))
            begin
                f = DIST_W'($urandom);
                b = DIST_W'($urandom);
                send_word(f, b);
            end
        end
    endtask

    // Phases at different thresholds, drained between phases
    task automatic test_random();
        int                target;
        int                phase_end;
        int                phase;
        logic [DIST_W-1:0] t;
        target = words_sent + 950;
        phase  = 0;
        while (words_sent < target)
        begin
            case (phase % 6)
                0:       t = THRESHOLD_RESET;
                1:       t = 15'd1;
                2:       t = DIST_MAX - 15'd1;
                3:       t = DIST_W'($urandom_range(40, 2));
                default: t = DIST_W'($urandom_range(DIST_MAX - 2, 2));
            endcase
            write_threshold(t);
            no_idle   = ($urandom_range(0, 3) == 0);
            phase_end = words_sent + $urandom_range(120, 200);
            while (words_sent < phase_end)
                random_sequence();
            phase++;
        end
        no_idle = 1'b0;
        drain();
    endtask

    // Output side stall pattern
    initial
    begin
        int hold;
        out_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            hold = idle_cycles();
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    task automatic check_field(input string what, input int expected, input int actual);
        if (expected != actual)
        begin
            error_count++;
            $display("%0t ns: %s expected %0d, got %0d", $time, what, expected, actual);
        end
    endtask

    // Result checker: each accepted word against the oldest prediction
    initial
    begin
        path_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t ns: unexpected word, expected none, got region %0d count %0d",
                             $time, region, occupancy_count);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("region", int'(want.region), int'(region));
                    check_field("occupancy_count", int'($signed(want.count)),
                                int'(occupancy_count));
                    check_field("crossing", int'(want.crossing), int'(crossing));
                    check_field("path_step", int'(want.step), int'(path_step));
                end
            end
        end
    end

    // Main sequence
    initial
    begin
        rst_n           = 1'b0;
        in_valid        <= 1'b0;
        front_distance  <= '0;
        back_distance   <= '0;
        threshold_we    <= 1'b0;
        threshold_wdata <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_boundaries();
        test_paths();
        test_threshold_extremes();
        test_count_wrap();
        test_random();

        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: two_zone_people_counter_core.f
hw/rtl/tzpc_pkg.sv
hw/rtl/tzpc_classify.sv
hw/rtl/tzpc_path.sv
hw/rtl/two_zone_people_counter_core.sv
test/tb.sv
